>>> hw/rtl/pgs_pkg.sv
package pgs_pkg;

    localparam int BUS_COUNT        = 4;
    localparam int ANGLE_TABLE_BITS = 10;

    localparam int POS_W    = 24;
    localparam int DIFF_W   = POS_W + 1;
    localparam int MAG_W    = POS_W;
    localparam int DIST_W   = 48;
    localparam int SQ_W     = DIST_W + 1;
    localparam int PAN_W    = 23;
    localparam int PREM_W   = PAN_W + 1;
    localparam int GAIN_W   = 16;
    localparam int PROD_W   = 2 * GAIN_W;
    localparam int Q15_BITS = 15;
    localparam int IDX_W    = ANGLE_TABLE_BITS + 1;
    localparam int NUM_W    = MAG_W + ANGLE_TABLE_BITS + 1;
    localparam int SINE_DEPTH = (1 << ANGLE_TABLE_BITS) + 1;
    localparam int DIV_STAGES = (IDX_W > Q15_BITS) ? IDX_W : Q15_BITS;

    localparam int ADDR_W  = 6;
    localparam int PDATA_W = 64;

    localparam logic [GAIN_W-1:0] Q15_ONE = 16'd32768;
    localparam logic [IDX_W-1:0]  IDX_MAX = IDX_W'(1 << ANGLE_TABLE_BITS);
    localparam logic [1:0]        BUS_LAST = 2'(BUS_COUNT - 1);

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // register map, index = paddr[5:3]
    localparam logic [2:0] REG_MIN_DIST = 3'd0;
    localparam logic [2:0] REG_MAX_DIST = 3'd1;
    localparam logic [2:0] REG_PAN      = 3'd2;
    localparam logic [2:0] REG_BUS0     = 3'd3;
    localparam logic [2:0] REG_BUS1     = 3'd4;
    localparam logic [2:0] REG_BUS2     = 3'd5;
    localparam logic [2:0] REG_BUS3     = 3'd6;

    typedef struct packed {
        logic [DIST_W-1:0]           min_dist_sq;
        logic [DIST_W-1:0]           max_dist_sq;
        logic [PAN_W-1:0]            pan_range;
        logic [3:0][GAIN_W-1:0]      bus_gain;
        logic [DIST_W-1:0]           span;
        logic [PREM_W-1:0]           pan_div;
    } cfg_t;

    typedef struct packed {
        logic              hp;
        logic [1:0]        bus;
        logic [GAIN_W-1:0] vol;
    } side_t;

    typedef struct packed {
        side_t                side;
        logic                 att_one;
        logic                 att_zero;
        logic [DIST_W-1:0]    att_rem;
        logic [Q15_BITS-1:0]  att_q;
        logic [PREM_W-1:0]    pan_rem;
        logic [IDX_W-1:0]     pan_low;
        logic [IDX_W-1:0]     pan_q;
    } div_t;

    typedef struct packed {
        logic              gains_valid;
        logic [GAIN_W-1:0] right_gain;
        logic [GAIN_W-1:0] left_gain;
    } gains_t;

    typedef logic [GAIN_W-1:0] sine_rom_t [0:SINE_DEPTH-1];

    // round a Q30 product back to Q1.15 and saturate at one
    function automatic logic [GAIN_W-1:0] q15_round(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        s = {1'b0, p} + (PROD_W+1)'(1 << (Q15_BITS - 1));
        if (s[PROD_W:Q15_BITS] > (PROD_W+1-Q15_BITS)'(Q15_ONE))
            return Q15_ONE;
        return s[Q15_BITS+GAIN_W-1:Q15_BITS];
    endfunction

    // quarter-wave sine by truncating Horner steps of the odd Taylor series
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned q;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            x  = (64'(i) * HALF_PI_Q30) >> ANGLE_TABLE_BITS;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            for (int k = 0; k < 5; k++) begin
                case (k)
                    0:       t = Q30_ONE - ((x2 * t) >> 30) / 110;
                    1:       t = Q30_ONE - ((x2 * t) >> 30) / 72;
                    2:       t = Q30_ONE - ((x2 * t) >> 30) / 42;
                    3:       t = Q30_ONE - ((x2 * t) >> 30) / 20;
                    default: t = Q30_ONE - ((x2 * t) >> 30) / 6;
                endcase
            end
            s = (x * t) >> 30;
            q = (s + 64'd16384) >> 15;
            rom[i] = (q > 64'd32768) ? Q15_ONE : q[GAIN_W-1:0];
        end
        return rom;
    endfunction

endpackage

>>> hw/rtl/pgs_geom.sv
module pgs_geom
    import pgs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic                    has_position,
    input  logic signed [POS_W-1:0] source_x,
    input  logic signed [POS_W-1:0] source_y,
    input  logic signed [POS_W-1:0] listener_x,
    input  logic signed [POS_W-1:0] listener_y,
    input  logic [GAIN_W-1:0]       voice_volume,
    input  logic [1:0]              bus_select,
    input  cfg_t                    cfg,
    output logic                    out_valid,
    output div_t                    out
);

    logic [4:0] v_reg;

    side_t                    side1_reg, side2_reg, side3_reg, side4_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg;
    logic [MAG_W-1:0]         adx2_reg, ady2_reg, n2_reg, n3_reg;
    logic [2*MAG_W-1:0]       sqx3_reg, sqy3_reg;
    logic [SQ_W-1:0]          d4_reg;
    logic [NUM_W-1:0]         num4_reg;
    div_t                     out_reg;

    logic [PAN_W-1:0]         pr;
    logic signed [DIFF_W-1:0] rng, xc, nsum, ndx, ndy;
    logic [MAG_W-1:0]         adx, ady;
    div_t                     out_next;

    assign pr  = (cfg.pan_range == '0) ? PAN_W'(1) : cfg.pan_range;
    assign rng = signed'({2'b00, pr});

    always_comb
    begin
        ndx = -dx1_reg;
        ndy = -dy1_reg;
        adx = dx1_reg[DIFF_W-1] ? ndx[MAG_W-1:0] : dx1_reg[MAG_W-1:0];
        ady = dy1_reg[DIFF_W-1] ? ndy[MAG_W-1:0] : dy1_reg[MAG_W-1:0];
        if (dx1_reg < -rng)
            xc = -rng;
        else if (dx1_reg > rng)
            xc = rng;
        else
            xc = dx1_reg;
        nsum = xc + rng;
    end

    always_comb
    begin
        out_next          = '0;
        out_next.side     = side4_reg;
        out_next.att_one  = d4_reg <= {1'b0, cfg.min_dist_sq};
        out_next.att_zero = d4_reg >= {1'b0, cfg.max_dist_sq};
        out_next.att_rem  = d4_reg[DIST_W-1:0] - cfg.min_dist_sq;
        out_next.pan_rem  = num4_reg[NUM_W-1:IDX_W];
        out_next.pan_low  = num4_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= '{hp: has_position, bus: bus_select, vol: voice_volume};
            dx1_reg   <= DIFF_W'(source_x) - DIFF_W'(listener_x);
            dy1_reg   <= DIFF_W'(source_y) - DIFF_W'(listener_y);

            side2_reg <= side1_reg;
            adx2_reg  <= adx;
            ady2_reg  <= ady;
            n2_reg    <= nsum[MAG_W-1:0];

            side3_reg <= side2_reg;
            sqx3_reg  <= adx2_reg * adx2_reg;
            sqy3_reg  <= ady2_reg * ady2_reg;
            n3_reg    <= n2_reg;

            side4_reg <= side3_reg;
            d4_reg    <= {1'b0, sqx3_reg} + {1'b0, sqy3_reg};
            num4_reg  <= {1'b0, n3_reg, {ANGLE_TABLE_BITS{1'b0}}} + NUM_W'(pr);

            out_reg   <= out_next;
        end
    end

    assign out_valid = v_reg[4];
    assign out       = out_reg;

endmodule

>>> hw/rtl/pgs_div.sv
module pgs_div
    import pgs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t in,
    input  cfg_t cfg,
    output logic out_valid,
    output div_t out
);

    // one quotient bit of each divide per stage while that divide has bits left
    logic [DIV_STAGES-1:0] v_reg;
    div_t                  st_reg  [DIV_STAGES];
    div_t                  st_next [DIV_STAGES];

    always_comb
    begin
        div_t              cur;
        div_t              nxt;
        logic [DIST_W:0]   arem2;
        logic [PREM_W:0]   prem2;
        logic              abit;
        logic              pbit;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            cur   = (i == 0) ? in : st_reg[(i == 0) ? 0 : i - 1];
            nxt   = cur;
            arem2 = {cur.att_rem, 1'b0};
            prem2 = {cur.pan_rem, cur.pan_low[IDX_W-1]};
            abit  = arem2 >= {1'b0, cfg.span};
            pbit  = prem2 >= {1'b0, cfg.pan_div};
            if (i < Q15_BITS)
            begin
                nxt.att_rem = abit ? DIST_W'(arem2 - {1'b0, cfg.span}) : arem2[DIST_W-1:0];
                nxt.att_q   = {cur.att_q[Q15_BITS-2:0], abit};
            end
            if (i < IDX_W)
            begin
                nxt.pan_rem = pbit ? PREM_W'(prem2 - {1'b0, cfg.pan_div}) : prem2[PREM_W-1:0];
                nxt.pan_low = {cur.pan_low[IDX_W-2:0], 1'b0};
                nxt.pan_q   = {cur.pan_q[IDX_W-2:0], pbit};
            end
            st_next[i] = nxt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DIV_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                st_reg[i] <= st_next[i];
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out       = st_reg[DIV_STAGES-1];

endmodule

>>> hw/rtl/pgs_gain.sv
module pgs_gain
    import pgs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  div_t   in,
    input  cfg_t   cfg,
    output logic   out_valid,
    output gains_t out
);

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    logic [4:0] v_reg;

    logic [GAIN_W-1:0] atten1_reg, vol1_reg;
    logic [IDX_W-1:0]  addr_r1_reg, addr_l1_reg;
    logic [GAIN_W-1:0] sin_l2_reg, sin_r2_reg;
    logic [PROD_W-1:0] p2_reg, pl3_reg, pr3_reg, pl4_reg, pr4_reg, pl5_reg, pr5_reg;
    logic [1:0]        bus1_reg, bus2_reg, bus3_reg, bus4_reg;
    logic              hp1_reg, hp2_reg, hp3_reg, hp4_reg, hp5_reg;

    logic [GAIN_W-1:0] atten_next, g3, bus_gain;
    logic [IDX_W-1:0]  idx_next;
    logic [1:0]        bsel;

    always_comb
    begin
        if (in.att_one)
            atten_next = Q15_ONE;
        else if (in.att_zero)
            atten_next = '0;
        else
            atten_next = Q15_ONE - GAIN_W'(in.att_q);
        idx_next = (in.pan_q > IDX_MAX) ? IDX_MAX : in.pan_q;
    end

    assign g3   = q15_round(p2_reg);
    assign bsel = (32'(bus4_reg) >= BUS_COUNT) ? BUS_LAST : bus4_reg;
    assign bus_gain = cfg.bus_gain[bsel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            atten1_reg  <= atten_next;
            vol1_reg    <= in.side.vol;
            addr_r1_reg <= idx_next;
            addr_l1_reg <= IDX_MAX - idx_next;
            bus1_reg    <= in.side.bus;
            hp1_reg     <= in.side.hp;

            sin_r2_reg  <= SINE_ROM[addr_r1_reg];
            sin_l2_reg  <= SINE_ROM[addr_l1_reg];
            p2_reg      <= vol1_reg * atten1_reg;
            bus2_reg    <= bus1_reg;
            hp2_reg     <= hp1_reg;

            pl3_reg     <= g3 * sin_l2_reg;
            pr3_reg     <= g3 * sin_r2_reg;
            bus3_reg    <= bus2_reg;
            hp3_reg     <= hp2_reg;

            pl4_reg     <= q15_round(pl3_reg) * cfg.bus_gain[0];
            pr4_reg     <= q15_round(pr3_reg) * cfg.bus_gain[0];
            bus4_reg    <= bus3_reg;
            hp4_reg     <= hp3_reg;

            pl5_reg     <= q15_round(pl4_reg) * bus_gain;
            pr5_reg     <= q15_round(pr4_reg) * bus_gain;
            hp5_reg     <= hp4_reg;
        end
    end

    // a source without position reports zero gains, flagged invalid
    assign out_valid       = v_reg[4];
    assign out.gains_valid = hp5_reg;
    assign out.left_gain   = hp5_reg ? q15_round(pl5_reg) : '0;
    assign out.right_gain  = hp5_reg ? q15_round(pr5_reg) : '0;

endmodule

>>> hw/rtl/positional_stereo_gain.sv
// Pipeline: 5 geometry stages, 15 divide stages and 5 table and gain stages,
// followed by the output register and its skid entry.
// Throughput: one request per cycle while the skid entry is empty; the 15-bit
// attenuation divide runs one quotient bit per stage, so its length sets the
// pipeline depth. Reset (rst_n low, asynchronous) clears all valid bits and loads
// the configuration registers with their defaults; no clearing pass is needed.
module positional_stereo_gain
    import pgs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // source_x, source_y, listener_x, listener_y, voice_volume
    input  logic [111:0]       s_axis_tdata,
    // has_position, bus_select
    input  logic [2:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // left_gain, right_gain
    output logic [31:0]        m_axis_tdata,
    // gains_valid
    output logic [0:0]         m_axis_tuser
);

    logic [DIST_W-1:0]      min_reg, max_reg, span_reg;
    logic [PAN_W-1:0]       pan_reg;
    logic [3:0][GAIN_W-1:0] bus_reg;
    logic [PREM_W-1:0]      pan_div_reg;
    cfg_t                   cfg;

    logic   en;
    logic   geom_valid, div_valid, gain_valid;
    div_t   geom_out, div_out;
    gains_t gain_out;

    logic   out_valid_reg, skid_valid_reg;
    gains_t out_reg, skid_reg;
    logic   wr;
    logic   take;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '0;
            max_reg <= DIST_W'(65536);
            pan_reg <= PAN_W'(256);
            bus_reg <= {4{Q15_ONE}};
        end
        else if (wr)
        begin
            case (paddr[5:3])
                REG_MIN_DIST: min_reg    <= pwdata[DIST_W-1:0];
                REG_MAX_DIST: max_reg    <= pwdata[DIST_W-1:0];
                REG_PAN:      pan_reg    <= pwdata[PAN_W-1:0];
                REG_BUS0:     bus_reg[0] <= pwdata[GAIN_W-1:0];
                REG_BUS1:     bus_reg[1] <= pwdata[GAIN_W-1:0];
                REG_BUS2:     bus_reg[2] <= pwdata[GAIN_W-1:0];
                REG_BUS3:     bus_reg[3] <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_MIN_DIST: prdata = PDATA_W'(min_reg);
            REG_MAX_DIST: prdata = PDATA_W'(max_reg);
            REG_PAN:      prdata = PDATA_W'(pan_reg);
            REG_BUS0:     prdata = PDATA_W'(bus_reg[0]);
            REG_BUS1:     prdata = PDATA_W'(bus_reg[1]);
            REG_BUS2:     prdata = PDATA_W'(bus_reg[2]);
            REG_BUS3:     prdata = PDATA_W'(bus_reg[3]);
            default:      prdata = '0;
        endcase
    end

    // divisors are registered, so they follow a register write in the next cycle
    always_ff @(posedge clk)
    begin
        span_reg    <= max_reg - min_reg;
        pan_div_reg <= {((pan_reg == '0) ? PAN_W'(1) : pan_reg), 1'b0};
    end

    assign cfg = '{min_dist_sq: min_reg, max_dist_sq: max_reg, pan_range: pan_reg,
                   bus_gain: bus_reg, span: span_reg, pan_div: pan_div_reg};

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    pgs_geom u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_axis_tvalid),
        .has_position (s_axis_tuser[0]),
        .source_x     (s_axis_tdata[23:0]),
        .source_y     (s_axis_tdata[47:24]),
        .listener_x   (s_axis_tdata[71:48]),
        .listener_y   (s_axis_tdata[95:72]),
        .voice_volume (s_axis_tdata[111:96]),
        .bus_select   (s_axis_tuser[2:1]),
        .cfg          (cfg),
        .out_valid    (geom_valid),
        .out          (geom_out)
    );

    pgs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (geom_valid),
        .in        (geom_out),
        .cfg       (cfg),
        .out_valid (div_valid),
        .out       (div_out)
    );

    pgs_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in        (div_out),
        .cfg       (cfg),
        .out_valid (gain_valid),
        .out       (gain_out)
    );

    assign take = en && gain_valid;

    // output register with one skid entry; the pipeline holds while the skid is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg  <= take;
        end
        else if (take)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else
                out_reg <= gain_out;
        end
        else if (take)
            skid_reg <= gain_out;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {out_reg.right_gain, out_reg.left_gain};
    assign m_axis_tuser[0] = out_reg.gains_valid;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output request");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && gain_valid && !skid_valid_reg) |=> skid_valid_reg)
        else $error("stalled result not captured in skid entry");

    a_no_position_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("gains nonzero for a source without position");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] <= Q15_ONE && m_axis_tdata[31:16] <= Q15_ONE))
        else $error("gain above unity");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pgs_pkg::*;

    typedef struct {
        logic              has_pos;
        logic [23:0]       src_x;
        logic [23:0]       src_y;
        logic [23:0]       lis_x;
        logic [23:0]       lis_y;
        logic [15:0]       volume;
        logic [1:0]        bus_sel;
    } source_t;

    typedef struct {
        logic        valid;
        logic [15:0] left;
        logic [15:0] right;
    } stereo_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [111:0]       s_axis_tdata;
    logic [2:0]         s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [31:0]        m_axis_tdata;
    logic [0:0]         m_axis_tuser;

    positional_stereo_gain u_dut (.*);

    // shadow of the register file
    longint unsigned min_dist_sq;
    longint unsigned max_dist_sq;
    longint unsigned pan_reach;
    longint unsigned bus_gain [4];
    logic [15:0]     sine_tab [0:1024];

    source_t pending_sources[$];
    stereo_t expected_gains[$];
    int      error_count;
    bit      calm;
    bit      send_hold;
    int      send_idle;
    int      recv_idle;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint unsigned q15_mul(longint unsigned a, longint unsigned b);
        longint unsigned p;
        p = (a * b + 16384) >> 15;
        return p > 32768 ? 32768 : p;
    endfunction

    function automatic void fill_sine();
        longint unsigned x, x2, t, s, q;
        longint unsigned dv [5];
        dv = '{110, 72, 42, 20, 6};
        for (int i = 0; i <= 1024; i++)
        begin
            x  = (longint'(i) * 64'd1686629713) >> 10;
            x2 = (x * x) >> 30;
            t  = 64'd1 << 30;
            for (int k = 0; k < 5; k++)
                t = (64'd1 << 30) - ((x2 * t) >> 30) / dv[k];
            s = (x * t) >> 30;
            q = (s + 16384) >> 15;
            sine_tab[i] = q > 32768 ? 16'd32768 : q[15:0];
        end
    endfunction

    function automatic stereo_t predict_gains(source_t s);
        stereo_t r;
        longint dx, dy, rr, xc;
        longint unsigned adx, ady, d, att, idx, g, lg, rg;
        r = '{1'b0, 16'd0, 16'd0};
        if (!s.has_pos)
            return r;
        dx  = longint'($signed(s.src_x)) - longint'($signed(s.lis_x));
        dy  = longint'($signed(s.src_y)) - longint'($signed(s.lis_y));
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        d   = adx * adx + ady * ady;
        if (d <= min_dist_sq)
            att = 32768;
        else if (d >= max_dist_sq)
            att = 0;
        else
            att = 32768 - ((d - min_dist_sq) * 32768) / (max_dist_sq - min_dist_sq);
        rr  = pan_reach == 0 ? 1 : pan_reach;
        xc  = dx < -rr ? -rr : (dx > rr ? rr : dx);
        idx = ((longint'(xc + rr) << 10) + rr) / (2 * rr);
        if (idx > 1024)
            idx = 1024;
        g  = q15_mul(s.volume, att);
        lg = q15_mul(g, sine_tab[1024 - idx]);
        rg = q15_mul(g, sine_tab[idx]);
        lg = q15_mul(q15_mul(lg, bus_gain[0]), bus_gain[s.bus_sel]);
        rg = q15_mul(q15_mul(rg, bus_gain[0]), bus_gain[s.bus_sel]);
        r = '{1'b1, lg[15:0], rg[15:0]};
        return r;
    endfunction

    task automatic write_reg(logic [2:0] index, longint unsigned value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_MIN_DIST: min_dist_sq = value & 64'hFFFF_FFFF_FFFF;
            REG_MAX_DIST: max_dist_sq = value & 64'hFFFF_FFFF_FFFF;
            REG_PAN:      pan_reach   = value & 64'h7F_FFFF;
            default:      bus_gain[index - REG_BUS0] = value & 64'hFFFF;
        endcase
    endtask

    task automatic drain();
        wait (pending_sources.size() == 0 && expected_gains.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_pos(int spread);
        if (spread == 0)
            return 24'($urandom);
        return 24'($signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic queue_source(logic hp, logic [23:0] sx, logic [23:0] sy,
                                logic [23:0] lx, logic [23:0] ly,
                                logic [15:0] vol, logic [1:0] bus);
        source_t s;
        s = '{hp, sx, sy, lx, ly, vol, bus};
        pending_sources.push_back(s);
    endtask

    task automatic queue_random(int n, int spread);
        logic [15:0] vol;
        for (int i = 0; i < n; i++)
        begin
            vol = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
            queue_source($urandom_range(0, 9) != 0, rand_pos(spread), rand_pos(spread),
                         rand_pos(spread), rand_pos(spread), vol, 2'($urandom));
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            send_idle     <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_gains.push_back(predict_gains(pending_sources.pop_front()));
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // hold the waiting request
            end
            else if (send_idle > 0)
            begin
                send_idle     <= send_idle - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (!calm && !send_hold && $urandom_range(0, 7) == 0)
            begin
                send_idle     <= $urandom_range(0, 9);
                s_axis_tvalid <= 1'b0;
            end
            else if (!send_hold && pending_sources.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {pending_sources[0].volume, pending_sources[0].lis_y,
                                  pending_sources[0].lis_x, pending_sources[0].src_y,
                                  pending_sources[0].src_x};
                s_axis_tuser  <= {pending_sources[0].bus_sel, pending_sources[0].has_pos};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_idle     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_gains.size() == 0)
                begin
                    $display("%t: unexpected result %h/%h", $time, m_axis_tuser, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    stereo_t e;
                    e = expected_gains.pop_front();
                    if (m_axis_tuser[0] !== e.valid || m_axis_tdata[15:0] !== e.left
                        || m_axis_tdata[31:16] !== e.right)
                    begin
                        $display("%t: expected valid %0d left %0d right %0d, got %0d %0d %0d",
                                 $time, e.valid, e.left, e.right, m_axis_tuser[0],
                                 m_axis_tdata[15:0], m_axis_tdata[31:16]);
                        error_count++;
                    end
                end
            end
            if (recv_idle > 0)
            begin
                recv_idle     <= recv_idle - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                recv_idle     <= $urandom_range(0, 9);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0; calm = 1'b0; send_hold = 1'b0;
        min_dist_sq = 0; max_dist_sq = 65536; pan_reach = 256;
        for (int i = 0; i < 4; i++)
            bus_gain[i] = 32768;
        fill_sine();
        repeat (8) @(posedge clk);
        rst_n = 1'b1;

        // directed: defaults, extremes, no position, pan ends, bus choice
        queue_source(1'b0, 24'h7FFFFF, 24'h800000, 24'h0, 24'h0, 16'hFFFF, 2'd3);
        queue_source(1'b1, 24'h0, 24'h0, 24'h0, 24'h0, 16'd32768, 2'd0);
        queue_source(1'b1, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 16'hFFFF, 2'd3);
        queue_source(1'b1, 24'h800000, 24'h0, 24'h7FFFFF, 24'h0, 16'd32768, 2'd1);
        queue_source(1'b1, 24'd100, 24'd0, 24'd0, 24'd0, 16'd32768, 2'd2);
        queue_source(1'b1, -24'sd100, 24'd50, 24'd0, 24'd0, 16'd20000, 2'd3);
        queue_source(1'b1, 24'd256, 24'd0, 24'd0, 24'd0, 16'd32768, 2'd0);
        queue_source(1'b1, -24'sd256, 24'd0, 24'd0, 24'd0, 16'd32768, 2'd1);
        queue_source(1'b1, 24'd0, 24'd255, 24'd0, 24'd0, 16'd0, 2'd2);
        drain();

        // inverted distances, zero pan range, oversize gains
        write_reg(REG_MIN_DIST, 64'd40000);
        write_reg(REG_MAX_DIST, 64'd30000);
        write_reg(REG_PAN, 64'd0);
        write_reg(REG_BUS0, 64'hFFFF);
        write_reg(REG_BUS1, 64'd0);
        write_reg(REG_BUS2, 64'd16384);
        write_reg(REG_BUS3, 64'd40000);
        for (int b = 0; b < 4; b++)
        begin
            queue_source(1'b1, 24'd100, 24'd100, 24'd0, 24'd0, 16'd30000, 2'(b));
            queue_source(1'b1, -24'sd1, 24'd0, 24'd0, 24'd0, 16'hFFFF, 2'(b));
        end
        queue_source(1'b1, 24'd300, 24'd0, 24'd0, 24'd0, 16'd32768, 2'd0);
        drain();

        // moderate settings, random geometry around the hearing range
        write_reg(REG_MIN_DIST, 64'd1 << 20);
        write_reg(REG_MAX_DIST, 64'd1 << 34);
        write_reg(REG_PAN, 64'd5000);
        write_reg(REG_BUS0, 64'd32768);
        write_reg(REG_BUS1, 64'd25000);
        write_reg(REG_BUS2, 64'd32768);
        write_reg(REG_BUS3, 64'd12345);
        queue_random(300, 100000);
        wait (pending_sources.size() < 150);
        // hold until the pipeline is empty
        send_hold = 1'b1;
        wait (expected_gains.size() == 0);
        send_hold = 1'b0;
        drain();

        // extreme registers, full-range positions
        write_reg(REG_MIN_DIST, 64'hFFFF_FFFF_FFFE);
        write_reg(REG_MAX_DIST, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_PAN, 64'h7F_FFFF);
        queue_random(300, 0);
        drain();

        write_reg(REG_MIN_DIST, 64'd0);
        write_reg(REG_MAX_DIST, 64'd1);
        write_reg(REG_PAN, 64'd1);
        queue_random(150, 4);
        drain();

        write_reg(REG_MIN_DIST, 64'($urandom_range(0, 1 << 30)));
        write_reg(REG_MAX_DIST, (64'($urandom) << 16) | 64'd1);
        write_reg(REG_PAN, 64'($urandom_range(1, 1 << 22)));
        write_reg(REG_BUS0, 64'($urandom_range(0, 32768)));
        queue_random(150, 1 << 20);
        drain();

        calm = 1'b1;
        queue_random(300, 1 << 16);
        drain();

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
